[design/ebalu_pkg.sv]
package ebalu_pkg;

  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_ADC    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_SBC    = 5'd3;
  localparam logic [4:0] OP_AND    = 5'd4;
  localparam logic [4:0] OP_XOR    = 5'd5;
  localparam logic [4:0] OP_OR     = 5'd6;
  localparam logic [4:0] OP_CP     = 5'd7;
  localparam logic [4:0] OP_INC    = 5'd8;
  localparam logic [4:0] OP_DEC    = 5'd9;
  localparam logic [4:0] OP_RLCA   = 5'd10;
  localparam logic [4:0] OP_RRCA   = 5'd11;
  localparam logic [4:0] OP_RLA    = 5'd12;
  localparam logic [4:0] OP_RRA    = 5'd13;
  localparam logic [4:0] OP_DAA    = 5'd14;
  localparam logic [4:0] OP_CPL    = 5'd15;
  localparam logic [4:0] OP_CCF    = 5'd16;
  localparam logic [4:0] OP_RLC    = 5'd17;
  localparam logic [4:0] OP_RRC    = 5'd18;
  localparam logic [4:0] OP_RL     = 5'd19;
  localparam logic [4:0] OP_RR     = 5'd20;
  localparam logic [4:0] OP_SLA    = 5'd21;
  localparam logic [4:0] OP_ADD_HL = 5'd22;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_LOW  = 8'h06;
  localparam logic [7:0] DAA_HIGH = 8'h60;
  localparam logic [7:0] DAA_MAX  = 8'h99;
  localparam logic [3:0] BCD_MAX  = 4'h9;

  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  value8;
    logic [15:0] hl_in;
    logic [15:0] value16;
  } req_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  reg_out;
    logic [15:0] hl_out;
    logic [3:0]  flags_out;
  } rsp_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [3:0] flags;
  } alu_state_t;

endpackage

[design/ebalu_core.sv]
module ebalu_core (
  input  ebalu_pkg::req_t       item,
  input  ebalu_pkg::alu_state_t state,
  output ebalu_pkg::rsp_t       result,
  output ebalu_pkg::alu_state_t state_next
);
  import ebalu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  v;
  logic [3:0]  f;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  diff9;
  logic [4:0]  diff5;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic        daa_c;
  logic [7:0]  daa_r;
  logic [7:0]  acc_new;
  logic [7:0]  reg_new;
  logic [15:0] hl_new;
  logic [3:0]  flags_new;

  assign a   = state.acc;
  assign f   = state.flags;
  assign v   = item.value8;
  assign cin = (item.op == OP_ADC || item.op == OP_SBC) ? f[FLAG_C] : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, v} + {8'd0, cin};
  assign sum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign diff9 = {1'b0, a} - {1'b0, v} - {8'd0, cin};
  assign diff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
  assign sum17 = {1'b0, item.hl_in} + {1'b0, item.value16};
  assign sum13 = {1'b0, item.hl_in[11:0]} + {1'b0, item.value16[11:0]};

  always_comb begin
    if (!f[FLAG_N]) begin
      daa_c = f[FLAG_C] || (a > DAA_MAX);
      daa_r = a + (daa_c ? DAA_HIGH : 8'd0)
                + ((f[FLAG_H] || (a[3:0] > BCD_MAX)) ? DAA_LOW : 8'd0);
    end else begin
      daa_c = f[FLAG_C];
      daa_r = a - (f[FLAG_C] ? DAA_HIGH : 8'd0) - (f[FLAG_H] ? DAA_LOW : 8'd0);
    end
  end

  always_comb begin
    acc_new   = a;
    reg_new   = 8'd0;
    flags_new = f;
    hl_new    = item.hl_in;
    case (item.op)
      OP_ADD, OP_ADC: begin
        acc_new   = sum9[7:0];
        flags_new = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        acc_new   = diff9[7:0];
        flags_new = {diff9[7:0] == 8'd0, 1'b1, diff5[4], diff9[8]};
      end
      OP_CP: begin
        flags_new = {diff9[7:0] == 8'd0, 1'b1, diff5[4], diff9[8]};
      end
      OP_AND: begin
        acc_new   = a & v;
        flags_new = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        acc_new   = a ^ v;
        flags_new = {(a ^ v) == 8'd0, 3'b000};
      end
      OP_OR: begin
        acc_new   = a | v;
        flags_new = {(a | v) == 8'd0, 3'b000};
      end
      OP_INC: begin
        reg_new   = v + 8'd1;
        flags_new = {reg_new == 8'd0, 1'b0, v[3:0] == 4'hF, f[FLAG_C]};
      end
      OP_DEC: begin
        reg_new   = v - 8'd1;
        flags_new = {reg_new == 8'd0, 1'b1, v[3:0] == 4'h0, f[FLAG_C]};
      end
      OP_RLCA: begin
        acc_new   = {a[6:0], a[7]};
        flags_new = {3'b000, a[7]};
      end
      OP_RRCA: begin
        acc_new   = {a[0], a[7:1]};
        flags_new = {3'b000, a[0]};
      end
      OP_RLA: begin
        acc_new   = {a[6:0], f[FLAG_C]};
        flags_new = {3'b000, a[7]};
      end
      OP_RRA: begin
        acc_new   = {f[FLAG_C], a[7:1]};
        flags_new = {3'b000, a[0]};
      end
      OP_DAA: begin
        acc_new   = daa_r;
        flags_new = {daa_r == 8'd0, f[FLAG_N], 1'b0, daa_c};
      end
      OP_CPL: begin
        acc_new   = ~a;
        flags_new = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
      end
      OP_CCF: begin
        flags_new = {f[FLAG_Z], 1'b0, 1'b0, ~f[FLAG_C]};
      end
      OP_RLC: begin
        reg_new   = {v[6:0], v[7]};
        flags_new = {reg_new == 8'd0, 2'b00, v[7]};
      end
      OP_RRC: begin
        reg_new   = {v[0], v[7:1]};
        flags_new = {reg_new == 8'd0, 2'b00, v[0]};
      end
      OP_RL: begin
        reg_new   = {v[6:0], f[FLAG_C]};
        flags_new = {reg_new == 8'd0, 2'b00, v[7]};
      end
      OP_RR: begin
        reg_new   = {f[FLAG_C], v[7:1]};
        flags_new = {reg_new == 8'd0, 2'b00, v[0]};
      end
      OP_SLA: begin
        reg_new   = {v[6:0], 1'b0};
        flags_new = {reg_new == 8'd0, 2'b00, v[7]};
      end
      OP_ADD_HL: begin
        hl_new    = sum17[15:0];
        flags_new = {f[FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      default: begin
        acc_new = a;
      end
    endcase
  end

  assign result.acc_out   = acc_new;
  assign result.reg_out   = reg_new;
  assign result.hl_out    = hl_new;
  assign result.flags_out = flags_new;
  assign state_next.acc   = acc_new;
  assign state_next.flags = flags_new;

endmodule

[design/eight_bit_alu_with_flags_top.sv]
// Eight-bit accumulator ALU with Z, N, H and C flags. Each accepted item runs one
// operation against the accumulator and flags held inside the block and returns one
// result item carrying the accumulator, the target register value, HL and the flags.
// The block takes one item per cycle while the result item is not stalled. An accepted
// item is held in the input register, and its result item is then presented from the
// result register. While a result item is stalled, the next item waits in the input
// register and the input is stalled. The accumulator and flags update in the single ALU
// stage between those registers, so back-to-back items see each other's results with no
// bubble. Reset clears the accumulator and flags to zero.
module eight_bit_alu_with_flags_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ebalu_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ebalu_pkg::rsp_t rsp
);
  import ebalu_pkg::*;

  req_t       item;
  logic       item_valid;
  alu_state_t state;
  alu_state_t state_next;
  rsp_t       result;
  logic       advance;
  logic       accept;

  assign advance   = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !advance;
  assign accept    = req_valid && !req_stall;

  ebalu_core u_core (
    .item       (item),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !advance |=> $stable(state))
    else $error("ALU state changed without an item moving to the result register.");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    !rst && advance |=> rsp.acc_out == state.acc && rsp.flags_out == state.flags)
    else $error("Result item disagrees with the updated accumulator or flags.");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> item_valid && rsp_valid)
    else $error("Input stalled while the pipeline had room.");

endmodule
